### rtl/tmprof_pkg.sv
package tmprof_pkg;

    // Field widths
    localparam int SPEED_W  = 16;
    localparam int TICK_W   = 16;
    localparam int KIND_W   = 4;
    localparam int LEN_W    = 8;
    localparam int TPC_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Turn profile windows, in ticks
    localparam logic [TICK_W-1:0] ACCEL_TICKS  = TICK_W'(50);
    localparam logic [TICK_W-1:0] CRUISE_TICKS = TICK_W'(100);
    localparam logic [TICK_W-1:0] DECEL_TICKS  = TICK_W'(50);
    localparam logic [TICK_W-1:0] CRUISE_END   = ACCEL_TICKS + CRUISE_TICKS;
    localparam logic [TICK_W-1:0] DECEL_END    = CRUISE_END + DECEL_TICKS;
    localparam logic [TICK_W-1:0] TICK_MAX     = '1;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Movement kind ranges: straight up to and including the first, turn up to the second
    localparam logic [KIND_W-1:0] KIND_STRAIGHT_LAST = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_TURN_LAST     = KIND_W'(9);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_MAX   = 3'd0,
        CFG_LIN_ACCEL = 3'd1,
        CFG_LIN_DECEL = 3'd2,
        CFG_LIN_END   = 3'd3,
        CFG_LIN_FLOOR = 3'd4,
        CFG_ANG_STEP  = 3'd5,
        CFG_ANG_MAX   = 3'd6,
        CFG_TICKS_CM  = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [SPEED_W-1:0] RST_LIN_MAX   = SPEED_W'(10000);
    localparam logic [SPEED_W-1:0] RST_LIN_ACCEL = SPEED_W'(50);
    localparam logic [SPEED_W-1:0] RST_LIN_DECEL = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] RST_LIN_END   = SPEED_W'(1100);
    localparam logic [SPEED_W-1:0] RST_LIN_FLOOR = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0] RST_ANG_STEP  = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0] RST_ANG_MAX   = SPEED_W'(55850);
    localparam logic [TPC_W-1:0]   RST_TICKS_CM  = TPC_W'(3);

    // One result beat
    typedef struct packed {
        logic [SPEED_W-1:0] linear_target;
        logic [SPEED_W-1:0] angular_target;
        logic               finished;
    } t_result;

endpackage

### rtl/tmprof_in_if.sv
interface tmprof_in_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [tmprof_pkg::KIND_W-1:0]       movement_kind;
    logic [tmprof_pkg::LEN_W-1:0]        length_cm;

    modport source (output valid, output req_type, output movement_kind, output length_cm,
                    input ready);
    modport sink   (input valid, input req_type, input movement_kind, input length_cm,
                    output ready);
endinterface

### rtl/tmprof_out_if.sv
interface tmprof_out_if;
    logic                                valid;
    logic                                ready;
    logic [tmprof_pkg::SPEED_W-1:0]      linear_target;
    logic [tmprof_pkg::SPEED_W-1:0]      angular_target;
    logic                                finished;

    modport source (output valid, output linear_target, output angular_target,
                    output finished, input ready);
    modport sink   (input valid, input linear_target, input angular_target,
                    input finished, output ready);
endinterface

### rtl/tmprof_cfg_if.sv
interface tmprof_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tmprof_pkg::CFG_IDX_W-1:0]    index;
    logic [tmprof_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/trapezoidal_motion_profile.sv
// Channel   Dir  Beat carries
// i_in      in   req_type, movement_kind, length_cm
// o_out     out  linear_target, angular_target, finished
// i_cfg     in   index, data (register write)
//
// One beat a cycle while the skid entry is empty: a request updates the profile
// state at the edge that accepts it, and its result is loaded at that edge into
// the output register, or into the one skid entry while a result waits there.
// Input stalls only when both the output and skid registers are full.
// Synchronous active-low reset: profile state and valids cleared, registers set to reset values.
// Configuration writes are always taken, one a cycle.
module trapezoidal_motion_profile #(
    parameter logic [tmprof_pkg::TICK_W-1:0] ACCEL_TICKS  = tmprof_pkg::ACCEL_TICKS,
    parameter logic [tmprof_pkg::TICK_W-1:0] CRUISE_TICKS = tmprof_pkg::CRUISE_TICKS,
    parameter logic [tmprof_pkg::TICK_W-1:0] DECEL_TICKS  = tmprof_pkg::DECEL_TICKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tmprof_in_if.sink            i_in,
    tmprof_out_if.source         o_out,
    tmprof_cfg_if.sink           i_cfg
);

    localparam int SW = tmprof_pkg::SPEED_W;
    localparam int TW = tmprof_pkg::TICK_W;

    // Turn window ends
    localparam logic [TW-1:0] CRUISE_END = ACCEL_TICKS + CRUISE_TICKS;
    localparam logic [TW-1:0] DECEL_END  = CRUISE_END + DECEL_TICKS;

    // Configuration registers
    logic [SW-1:0] r_lin_max, r_lin_accel, r_lin_decel, r_lin_end, r_lin_floor;
    logic [SW-1:0] r_ang_step, r_ang_max;
    logic [tmprof_pkg::TPC_W-1:0] r_ticks_cm;

    // Profile state
    logic [SW-1:0] r_lin_speed, n_lin_speed;
    logic [SW-1:0] r_ang_speed, n_ang_speed;
    logic [TW-1:0] r_elapsed, n_elapsed;
    logic [tmprof_pkg::KIND_W-1:0] r_mode, n_mode;
    logic [tmprof_pkg::LEN_W-1:0]  r_length, n_length;
    logic          r_finished, n_finished;

    // Output register and skid entry
    tmprof_pkg::t_result r_out, r_skid, n_result;
    logic                r_out_valid, r_skid_valid;

    logic in_fire, out_free;
    logic [TW-1:0] limit;
    logic [SW:0]   lin_sum, lin_diff, ang_sum;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && !r_skid_valid;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.linear_target  = r_out.linear_target;
    assign o_out.angular_target = r_out.angular_target;
    assign o_out.finished       = r_out.finished;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_max   <= tmprof_pkg::RST_LIN_MAX;
            r_lin_accel <= tmprof_pkg::RST_LIN_ACCEL;
            r_lin_decel <= tmprof_pkg::RST_LIN_DECEL;
            r_lin_end   <= tmprof_pkg::RST_LIN_END;
            r_lin_floor <= tmprof_pkg::RST_LIN_FLOOR;
            r_ang_step  <= tmprof_pkg::RST_ANG_STEP;
            r_ang_max   <= tmprof_pkg::RST_ANG_MAX;
            r_ticks_cm  <= tmprof_pkg::RST_TICKS_CM;
        end else if (i_cfg.valid) begin
            case (tmprof_pkg::t_cfg_idx'(i_cfg.index))
                tmprof_pkg::CFG_LIN_MAX:   r_lin_max   <= i_cfg.data;
                tmprof_pkg::CFG_LIN_ACCEL: r_lin_accel <= i_cfg.data;
                tmprof_pkg::CFG_LIN_DECEL: r_lin_decel <= i_cfg.data;
                tmprof_pkg::CFG_LIN_END:   r_lin_end   <= i_cfg.data;
                tmprof_pkg::CFG_LIN_FLOOR: r_lin_floor <= i_cfg.data;
                tmprof_pkg::CFG_ANG_STEP:  r_ang_step  <= i_cfg.data;
                tmprof_pkg::CFG_ANG_MAX:   r_ang_max   <= i_cfg.data;
                tmprof_pkg::CFG_TICKS_CM:  r_ticks_cm  <= i_cfg.data[tmprof_pkg::TPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Ramp arithmetic, one extra bit for carry and borrow
    assign limit    = TW'(r_length) * TW'(r_ticks_cm);
    assign lin_sum  = {1'b0, r_lin_speed} + {1'b0, r_lin_accel};
    assign lin_diff = {1'b0, r_lin_speed} - {1'b0, r_lin_decel};
    assign ang_sum  = {1'b0, r_ang_speed} + {1'b0, r_ang_step};

    // Next profile state
    always_comb begin
        n_lin_speed = r_lin_speed;
        n_ang_speed = r_ang_speed;
        n_elapsed   = r_elapsed;
        n_mode      = r_mode;
        n_length    = r_length;
        n_finished  = r_finished;
        if (i_in.req_type == tmprof_pkg::REQ_START) begin
            n_elapsed  = '0;
            n_finished = 1'b0;
            n_mode     = i_in.movement_kind;
            n_length   = i_in.length_cm;
        end else begin
            if (r_mode <= tmprof_pkg::KIND_STRAIGHT_LAST) begin
                // straight: accelerate inside the window, then brake to the floor
                if (r_elapsed < limit) begin
                    if (r_lin_speed < r_lin_max) begin
                        n_lin_speed = (lin_sum < {1'b0, r_lin_max}) ? lin_sum[SW-1:0]
                                                                   : r_lin_max;
                    end
                end else if (r_lin_speed > r_lin_end) begin
                    n_lin_speed = (lin_diff[SW] || lin_diff[SW-1:0] < r_lin_floor)
                                  ? r_lin_floor : lin_diff[SW-1:0];
                end else begin
                    n_finished = 1'b1;
                end
                n_ang_speed = '0;
            end else if (r_mode <= tmprof_pkg::KIND_TURN_LAST) begin
                // turn: fixed accelerate, cruise and decelerate windows
                n_lin_speed = '0;
                if (r_elapsed <= ACCEL_TICKS) begin
                    n_ang_speed = (ang_sum < {1'b0, r_ang_max}) ? ang_sum[SW-1:0] : r_ang_max;
                end else if (r_elapsed <= CRUISE_END) begin
                    n_ang_speed = r_ang_max;
                end else if (r_elapsed <= DECEL_END) begin
                    n_ang_speed = (r_ang_speed > r_ang_step) ? r_ang_speed - r_ang_step : '0;
                end else begin
                    n_ang_speed = '0;
                    n_finished  = 1'b1;
                end
            end
            // saturating tick count
            if (r_elapsed != tmprof_pkg::TICK_MAX) begin
                n_elapsed = r_elapsed + TW'(1);
            end
        end
        n_result.linear_target  = n_lin_speed;
        n_result.angular_target = n_ang_speed;
        n_result.finished       = n_finished;
    end

    // State update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_speed <= '0;
            r_ang_speed <= '0;
            r_elapsed   <= '0;
            r_mode      <= '0;
            r_length    <= '0;
            r_finished  <= 1'b0;
        end else if (in_fire) begin
            r_lin_speed <= n_lin_speed;
            r_ang_speed <= n_ang_speed;
            r_elapsed   <= n_elapsed;
            r_mode      <= n_mode;
            r_length    <= n_length;
            r_finished  <= n_finished;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

endmodule

### dv/tmprof_checker.sv
`timescale 1ns / 100ps
// Watches the request, result and register channels, keeps its own copy of the
// profile state and checks every result beat against the oldest prediction.
module tmprof_checker
    import tmprof_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tmprof_in_if  i_in,
    tmprof_out_if i_out,
    tmprof_cfg_if i_cfg,
    output int    o_fail_count,
    output int    o_pending
);

    // Register copies
    logic [SPEED_W-1:0] lin_max;
    logic [SPEED_W-1:0] lin_accel;
    logic [SPEED_W-1:0] lin_decel;
    logic [SPEED_W-1:0] lin_end;
    logic [SPEED_W-1:0] lin_floor;
    logic [SPEED_W-1:0] ang_step;
    logic [SPEED_W-1:0] ang_max;
    logic [TPC_W-1:0]   ticks_cm;

    // Profile state
    logic [SPEED_W-1:0] lin_speed;
    logic [SPEED_W-1:0] ang_speed;
    logic [TICK_W-1:0]  elapsed;
    logic [KIND_W-1:0]  mode;
    logic [LEN_W-1:0]   move_len;
    logic               done;

    t_result            target_q[$];
    int                 mismatches = 0;

    // Advance the profile by one request beat and queue the targets it leaves
    task automatic step_profile(input logic req, input logic [KIND_W-1:0] kind,
                                input logic [LEN_W-1:0] len);
        logic [SPEED_W:0]  sum;
        logic [TICK_W-1:0] accel_window;
        t_result           res;
        if (req == REQ_START) begin
            elapsed  = '0;
            done     = 1'b0;
            mode     = kind;
            move_len = len;
        end else begin
            if (mode <= KIND_STRAIGHT_LAST) begin
                // straight: ramp up inside the window, then brake towards the floor
                accel_window = TICK_W'(move_len) * TICK_W'(ticks_cm);
                if (elapsed < accel_window) begin
                    if (lin_speed < lin_max) begin
                        sum       = {1'b0, lin_speed} + {1'b0, lin_accel};
                        lin_speed = (sum < {1'b0, lin_max}) ? sum[SPEED_W-1:0] : lin_max;
                    end
                end else if (lin_speed > lin_end) begin
                    // floor may sit above the current speed and pull it up
                    if (lin_speed < lin_decel || (lin_speed - lin_decel) < lin_floor)
                        lin_speed = lin_floor;
                    else
                        lin_speed = lin_speed - lin_decel;
                end else begin
                    done = 1'b1;
                end
                ang_speed = '0;
            end else if (mode <= KIND_TURN_LAST) begin
                // turn: accelerate, cruise, decelerate, then stop
                lin_speed = '0;
                if (elapsed <= ACCEL_TICKS) begin
                    sum       = {1'b0, ang_speed} + {1'b0, ang_step};
                    ang_speed = (sum < {1'b0, ang_max}) ? sum[SPEED_W-1:0] : ang_max;
                end else if (elapsed <= CRUISE_END) begin
                    ang_speed = ang_max;
                end else if (elapsed <= DECEL_END) begin
                    ang_speed = (ang_speed > ang_step) ? ang_speed - ang_step : '0;
                end else begin
                    ang_speed = '0;
                    done      = 1'b1;
                end
            end
            // tick count saturates
            if (elapsed != TICK_MAX)
                elapsed = elapsed + 1'b1;
        end
        res.linear_target  = lin_speed;
        res.angular_target = ang_speed;
        res.finished       = done;
        target_q.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [SPEED_W-1:0] want,
                               input logic [SPEED_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            lin_max   = RST_LIN_MAX;
            lin_accel = RST_LIN_ACCEL;
            lin_decel = RST_LIN_DECEL;
            lin_end   = RST_LIN_END;
            lin_floor = RST_LIN_FLOOR;
            ang_step  = RST_ANG_STEP;
            ang_max   = RST_ANG_MAX;
            ticks_cm  = RST_TICKS_CM;
            lin_speed = '0;
            ang_speed = '0;
            elapsed   = '0;
            mode      = '0;
            move_len  = '0;
            done      = 1'b0;
            target_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_LIN_MAX:   lin_max   = i_cfg.data;
                    CFG_LIN_ACCEL: lin_accel = i_cfg.data;
                    CFG_LIN_DECEL: lin_decel = i_cfg.data;
                    CFG_LIN_END:   lin_end   = i_cfg.data;
                    CFG_LIN_FLOOR: lin_floor = i_cfg.data;
                    CFG_ANG_STEP:  ang_step  = i_cfg.data;
                    CFG_ANG_MAX:   ang_max   = i_cfg.data;
                    CFG_TICKS_CM:  ticks_cm  = i_cfg.data[TPC_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                step_profile(i_in.req_type, i_in.movement_kind, i_in.length_cm);
            if (i_out.valid && i_out.ready) begin
                if (target_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, got lin %0d ang %0d fin %0d",
                             $time, i_out.linear_target, i_out.angular_target,
                             i_out.finished);
                end else begin
                    want = target_q.pop_front();
                    check_field("linear_target", want.linear_target, i_out.linear_target);
                    check_field("angular_target", want.angular_target, i_out.angular_target);
                    check_field("finished", SPEED_W'(want.finished),
                                SPEED_W'(i_out.finished));
                end
            end
        end
        o_pending    <= target_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### dv/tb_trapezoidal_motion_profile.sv
`timescale 1ns / 100ps
// Drives request beats and register writes into the profile generator; the
// checker beside it predicts and compares, this module gives the verdict.
module tb_trapezoidal_motion_profile;
    import tmprof_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int SEGMENT_ITEMS = 60;
    localparam int KIND_TOP      = (1 << KIND_W) - 1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tmprof_in_if  in_ch ();
    tmprof_out_if out_ch ();
    tmprof_cfg_if cfg_ch ();

    int         fail_count;
    int         pending;
    int         send_idle_pct = 22;
    int         recv_idle_pct = 58;
    int         stall_cycles  = 0;
    logic [TPC_W-1:0] cur_tpc = RST_TICKS_CM;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    trapezoidal_motion_profile i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tmprof_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One request beat, with random gaps ahead of it
    task automatic send_beat(input logic req, input logic [KIND_W-1:0] kind,
                             input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= req;
        in_ch.movement_kind <= kind;
        in_ch.length_cm     <= len;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_beat(REQ_TICK, KIND_W'($urandom_range(KIND_TOP)), LEN_W'($urandom));
    endtask

    // Hold requests back until every outstanding result has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_DAT_W-1:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_idx'(i);
            cfg_ch.data  <= vals[i];
            @(posedge i_clk);
            while (!cfg_ch.ready)
                @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_tpc = vals[CFG_TICKS_CM][TPC_W-1:0];
    endtask

    // A start followed by a run of ticks, or now and then a lone stray beat
    task automatic run_sequence(inout int count);
        int                pick;
        int                ticks;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [TICK_W-1:0] window;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_beat(1'($urandom_range(1)), KIND_W'($urandom_range(KIND_TOP)),
                      LEN_W'($urandom));
            count++;
        end else begin
            len  = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(15)) : LEN_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 45) begin
                kind   = KIND_W'($urandom_range(KIND_STRAIGHT_LAST));
                window = TICK_W'(len) * TICK_W'(cur_tpc);
                ticks  = ((window > 250) ? 250 : int'(window)) + $urandom_range(150);
            end else if (pick < 85) begin
                kind  = KIND_W'($urandom_range(KIND_TURN_LAST, KIND_STRAIGHT_LAST + 1));
                ticks = ($urandom_range(99) < 30) ? $urandom_range(215, 195)
                                                  : $urandom_range(60);
            end else begin
                kind  = KIND_W'($urandom_range(KIND_TOP, KIND_TURN_LAST + 1));
                ticks = $urandom_range(5);
            end
            send_beat(REQ_START, kind, len);
            count++;
            repeat (ticks) begin
                send_tick();
                count++;
            end
        end
    endtask

    initial begin
        logic [CFG_DAT_W-1:0] regs [8];
        int                   seg_items;
        in_ch.valid         <= 1'b0;
        in_ch.req_type      <= REQ_TICK;
        in_ch.movement_kind <= '0;
        in_ch.length_cm     <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_LIN_MAX;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats on reset settings
        // tick before any start: zero length straight finishes at once
        send_beat(REQ_TICK, '0, '0);
        // longest straight, every length bit set
        send_beat(REQ_START, '0, '1);
        repeat (3) send_beat(REQ_TICK, KIND_W'(KIND_TOP), '1);
        // three tick window, then below the end speed it finishes and stays so
        send_beat(REQ_START, KIND_STRAIGHT_LAST, LEN_W'(1));
        repeat (6) send_beat(REQ_TICK, '0, '0);
        // idle kind: speeds held, only the count moves
        send_beat(REQ_START, KIND_W'(KIND_TOP), '0);
        repeat (2) send_tick();
        // first and last turn kinds
        send_beat(REQ_START, KIND_STRAIGHT_LAST + 1'b1, LEN_W'(8'hAA));
        repeat (3) send_tick();
        send_beat(REQ_START, KIND_TURN_LAST, LEN_W'(8'h55));
        repeat (2) send_tick();
        send_beat(REQ_START, KIND_TURN_LAST + 1'b1, '0);
        send_tick();

        // Random part: three idling phases, two register settings in each
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 22 : (p == 1) ? 58 : 0;
            recv_idle_pct = (p == 0) ? 58 : (p == 1) ? 22 : 0;
            for (int j = 0; j < 2; j++) begin
                case (2 * p + j)
                    0: regs = '{default: '1};
                    1: regs = '{default: '0};
                    2: begin
                        // floor above end speed
                        regs[CFG_LIN_MAX]   = 16'd8000;
                        regs[CFG_LIN_ACCEL] = 16'd900;
                        regs[CFG_LIN_DECEL] = 16'd250;
                        regs[CFG_LIN_END]   = 16'd1500;
                        regs[CFG_LIN_FLOOR] = 16'd4000;
                        regs[CFG_ANG_STEP]  = 16'd2500;
                        regs[CFG_ANG_MAX]   = 16'd30000;
                        regs[CFG_TICKS_CM]  = 16'h5A02;
                    end
                    3: begin
                        regs[CFG_LIN_MAX]   = RST_LIN_MAX;
                        regs[CFG_LIN_ACCEL] = RST_LIN_ACCEL;
                        regs[CFG_LIN_DECEL] = RST_LIN_DECEL;
                        regs[CFG_LIN_END]   = RST_LIN_END;
                        regs[CFG_LIN_FLOOR] = RST_LIN_FLOOR;
                        regs[CFG_ANG_STEP]  = RST_ANG_STEP;
                        regs[CFG_ANG_MAX]   = RST_ANG_MAX;
                        regs[CFG_TICKS_CM]  = CFG_DAT_W'(RST_TICKS_CM);
                    end
                    default: begin
                        regs[CFG_LIN_MAX]   = CFG_DAT_W'($urandom);
                        regs[CFG_LIN_ACCEL] = CFG_DAT_W'($urandom_range(3000));
                        regs[CFG_LIN_DECEL] = CFG_DAT_W'($urandom_range(3000));
                        regs[CFG_LIN_END]   = CFG_DAT_W'($urandom_range(4000));
                        regs[CFG_LIN_FLOOR] = CFG_DAT_W'($urandom_range(4000));
                        regs[CFG_ANG_STEP]  = CFG_DAT_W'($urandom_range(5000));
                        regs[CFG_ANG_MAX]   = CFG_DAT_W'($urandom);
                        regs[CFG_TICKS_CM]  = {8'($urandom), 8'($urandom_range(6))};
                    end
                endcase
                drain();
                program_regs(regs);
                seg_items = 0;
                while (seg_items < SEGMENT_ITEMS)
                    run_sequence(seg_items);
            end
        end

        // Slow ramp with a full decel step; the ticks sent stay inside the ramp window, so no braking
        regs[CFG_LIN_MAX]   = 16'd40000;
        regs[CFG_LIN_ACCEL] = 16'd1;
        regs[CFG_LIN_DECEL] = '1;
        regs[CFG_LIN_END]   = 16'd500;
        regs[CFG_LIN_FLOOR] = 16'd200;
        regs[CFG_ANG_STEP]  = 16'd1000;
        regs[CFG_ANG_MAX]   = 16'd1000;
        regs[CFG_TICKS_CM]  = 16'h00FF;
        drain();
        program_regs(regs);
        send_beat(REQ_START, KIND_STRAIGHT_LAST, LEN_W'(2));
        repeat (8) send_tick();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
